@@ src/ftws_pkg.sv @@
package ftws_pkg;

	// Default ring depth
	localparam int unsigned WINDOW_DEF = 64;

	// Field widths fixed by the interface
	localparam int unsigned DUR_W  = 32;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned PCT_W  = 7;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;

	// Register reset values
	localparam logic [DUR_W-1:0] OVER_THR_RST   = 32'd50000;
	localparam logic [PCT_W-1:0] PERCENTILE_RST = 7'd95;

	// Percent scale used in the rank test
	localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVER_THR   = 1'b0,
		REG_PERCENTILE = 1'b1
	} cfg_reg_e;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_e;

	// Control from the sequencer to the statistics unit
	typedef struct packed {
		logic clear;
		logic step;
	} stats_ctl_t;

endpackage

@@ src/ftws_in_if.sv @@
interface ftws_in_if;
	logic                          valid;
	logic                          ready;
	logic [ftws_pkg::DUR_W-1:0]    frame_us;

	modport source (output valid, output frame_us, input ready);
	modport sink   (input valid, input frame_us, output ready);
endinterface

@@ src/ftws_out_if.sv @@
interface ftws_out_if;
	logic                          valid;
	logic                          ready;
	logic [ftws_pkg::CNT_W-1:0]    samples;
	logic [ftws_pkg::DUR_W-1:0]    pct_us;
	logic [ftws_pkg::DUR_W-1:0]    max_us;
	logic [ftws_pkg::CNT_W-1:0]    over_count;

	modport source (output valid, output samples, output pct_us, output max_us,
		output over_count, input ready);
	modport sink   (input valid, input samples, input pct_us, input max_us,
		input over_count, output ready);
endinterface

@@ src/ftws_cell.sv @@
// One slot of the sorted ring: duration plus age, shifted from its neighbor
module ftws_cell #(
	parameter int unsigned AW = 6
) (
	input  logic                       clk,
	input  logic                       shift,
	input  logic [ftws_pkg::DUR_W-1:0] d_val,
	input  logic [AW-1:0]              d_age,
	output logic [ftws_pkg::DUR_W-1:0] q_val,
	output logic [AW-1:0]              q_age
);

	logic [ftws_pkg::DUR_W-1:0] val_q;
	logic [AW-1:0]              age_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= d_val;
			age_q <= d_age;
		end
	end

	assign q_val = val_q;
	assign q_age = age_q;

endmodule

@@ src/ftws_merge.sv @@
// Head cell of the ring. Holds one element and passes on the smaller of
// held and incoming, so the new duration sinks into place in one lap.
// Empty slots count as larger than any duration and stay past the end of
// the live list. The oldest entry is skipped at the tail: from that step on
// the lap reads the cell in front of the tail, which closes the gap.
module ftws_merge #(
	parameter int unsigned WINDOW = 64,
	parameter int unsigned AW     = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       shift,
	input  logic [ftws_pkg::DUR_W-1:0] new_val,
	input  logic                       x_live,
	input  logic [ftws_pkg::DUR_W-1:0] x_val,
	input  logic [AW-1:0]              x_age,
	input  logic                       y_live,
	input  logic [ftws_pkg::DUR_W-1:0] y_val,
	input  logic [AW-1:0]              y_age,
	output logic                       e_live,
	output logic [ftws_pkg::DUR_W-1:0] e_val,
	output logic [AW-1:0]              e_age
);

	logic                       h_live_q;
	logic [ftws_pkg::DUR_W-1:0] h_val_q;
	logic [AW-1:0]              h_age_q;
	logic                       skip_q;

	logic                       drop_now;
	logic                       use_y;
	logic                       in_live;
	logic [ftws_pkg::DUR_W-1:0] in_val;
	logic [AW-1:0]              in_age;
	logic                       take_x;

	// Oldest entry at the tail drops out; read one cell ahead from then on
	assign drop_now = !skip_q && x_live && (x_age == AW'(WINDOW - 1));
	assign use_y    = skip_q || drop_now;
	assign in_live  = use_y ? y_live : x_live;
	assign in_val   = use_y ? y_val : x_val;
	assign in_age   = (use_y ? y_age : x_age) + AW'(1);
	assign take_x   = in_live && (!h_live_q || (in_val < h_val_q));

	// Emit the smaller element
	always_comb begin
		if (take_x) begin
			e_live = 1'b1;
			e_val  = in_val;
			e_age  = in_age;
		end else begin
			e_live = h_live_q;
			e_val  = h_val_q;
			e_age  = h_age_q;
		end
	end

	// Hold register: new duration at lap start, then the larger element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_live_q <= 1'b0;
			skip_q   <= 1'b0;
		end else if (load) begin
			h_live_q <= 1'b1;
			skip_q   <= 1'b0;
		end else if (shift) begin
			if (!take_x) begin
				h_live_q <= in_live;
			end
			if (drop_now) begin
				skip_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			h_val_q <= new_val;
			h_age_q <= '0;
		end else if (shift && !take_x) begin
			h_val_q <= in_val;
			h_age_q <= in_age;
		end
	end

endmodule

@@ src/ftws_stats.sv @@
// Watches the ascending stream leaving the head cell: picks the value at
// the percentile rank and the last live value, and counts values over
// the threshold.
module ftws_stats #(
	parameter int unsigned CW  = 7,
	parameter int unsigned NPW = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ftws_pkg::stats_ctl_t       ctl,
	input  logic [NPW-1:0]             np_in,
	input  logic [CW-1:0]              n,
	input  logic [ftws_pkg::DUR_W-1:0] thr,
	input  logic                       e_live,
	input  logic [ftws_pkg::DUR_W-1:0] e_val,
	output logic [ftws_pkg::DUR_W-1:0] pct_val,
	output logic [ftws_pkg::DUR_W-1:0] max_val,
	output logic [CW-1:0]              over_cnt
);

	logic [NPW-1:0]             np_q;
	logic [CW-1:0]              pos_q;
	logic                       got_q;
	logic [CW-1:0]              over_q;
	logic [ftws_pkg::DUR_W-1:0] pct_q;
	logic [ftws_pkg::DUR_W-1:0] max_q;

	logic [CW-1:0]              pos;
	logic [NPW-1:0]             pos_scaled;
	logic                       is_last;
	logic                       hit;

	// Rank test: first position p with p*100 >= n*percentile, else the last
	assign pos        = pos_q + CW'(1);
	assign pos_scaled = NPW'(pos) * NPW'(ftws_pkg::PCT_SCALE);
	assign is_last    = (pos == n);
	assign hit        = !got_q && ((pos_scaled >= np_q) || is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			got_q  <= 1'b0;
			over_q <= '0;
		end else if (ctl.clear) begin
			pos_q  <= '0;
			got_q  <= 1'b0;
			over_q <= '0;
		end else if (ctl.step && e_live) begin
			pos_q <= pos;
			if (hit) begin
				got_q <= 1'b1;
			end
			if (e_val > thr) begin
				over_q <= over_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			np_q <= np_in;
		end
		if (ctl.step && e_live) begin
			if (hit) begin
				pct_q <= e_val;
			end
			if (is_last) begin
				max_q <= e_val;
			end
		end
	end

	assign pct_val  = pct_q;
	assign max_val  = max_q;
	assign over_cnt = over_q;

endmodule

@@ src/frame_time_window_stats.sv @@
// Sliding-window frame-time statistics. Each input beat carries one frame
// duration; the block keeps the WINDOW most recent durations in a ring of
// cells sorted ascending and, for every input beat, returns one output beat
// with the number held, the value at the configured percentile rank
// (ceil(count*percentile/100), clamped to 1..count), the maximum, and how
// many exceed over_threshold_us. An item goes through the accept cycle, one
// lap of the ring through the single merge cell at its head (one cell step
// per cycle), and the load of the output register. The load waits while the
// previous result still sits unread in the output register, and each such
// cycle adds to the item time; the next item is taken in the cycle after the
// load. Registers are to be written by the user only while idle; the block
// does not enforce it. samples and over_count are the low 7 bits.
module frame_time_window_stats #(
	parameter int unsigned WINDOW = ftws_pkg::WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ftws_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ftws_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ftws_in_if.sink                         frame,
	ftws_out_if.source                      stats
);

	localparam int unsigned AW  = $clog2(WINDOW);
	localparam int unsigned CW  = $clog2(WINDOW + 1);
	localparam int unsigned NPW = CW + ftws_pkg::PCT_W;
	localparam int unsigned DW  = ftws_pkg::DUR_W;

	ftws_pkg::state_e state_q, state_d;

	logic [DW-1:0]                over_thr_q;
	logic [ftws_pkg::PCT_W-1:0]   percentile_q;
	logic [CW-1:0]                fill_q;
	logic [CW-1:0]                n_old_q;
	logic [AW-1:0]                k_q;

	logic                         accept;
	logic                         shift;
	logic                         last_step;
	logic                         out_free;
	logic                         out_load;
	logic [CW-1:0]                n_new;
	logic [NPW-1:0]               np;
	ftws_pkg::stats_ctl_t         sctl;

	logic                         x_live;
	logic                         y_live;
	logic                         e_live;
	logic [DW-1:0]                e_val;
	logic [AW-1:0]                e_age;
	logic [DW-1:0]                c_val [WINDOW];
	logic [AW-1:0]                c_age [WINDOW];

	logic [DW-1:0]                pct_val;
	logic [DW-1:0]                max_val;
	logic [CW-1:0]                over_cnt;

	logic                         out_valid_q;
	logic [ftws_pkg::CNT_W-1:0]   samples_q;
	logic [DW-1:0]                pct_q;
	logic [DW-1:0]                max_q;
	logic [ftws_pkg::CNT_W-1:0]   over_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_thr_q   <= ftws_pkg::OVER_THR_RST;
			percentile_q <= ftws_pkg::PERCENTILE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ftws_pkg::REG_OVER_THR:   over_thr_q   <= cfg_wdata[DW-1:0];
				ftws_pkg::REG_PERCENTILE: percentile_q <= cfg_wdata[ftws_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake terms
	assign accept    = frame.valid && frame.ready;
	assign last_step = (k_q == AW'(WINDOW - 1));
	assign out_free  = !out_valid_q || stats.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ftws_pkg::ST_IDLE: begin
				if (accept) state_d = ftws_pkg::ST_RUN;
			end
			ftws_pkg::ST_RUN: begin
				if (last_step) state_d = ftws_pkg::ST_FINISH;
			end
			ftws_pkg::ST_FINISH: begin
				if (out_free) state_d = ftws_pkg::ST_IDLE;
			end
			default: state_d = ftws_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		frame.ready = 1'b0;
		shift       = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ftws_pkg::ST_IDLE:   frame.ready = 1'b1;
			ftws_pkg::ST_RUN:    shift       = 1'b1;
			ftws_pkg::ST_FINISH: out_load    = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Fill count and lap counter
	assign n_new = (fill_q == CW'(WINDOW)) ? fill_q : fill_q + CW'(1);
	assign np    = NPW'(n_new) * NPW'(percentile_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			n_old_q <= '0;
			k_q     <= '0;
		end else if (accept) begin
			fill_q  <= n_new;
			n_old_q <= fill_q;
			k_q     <= '0;
		end else if (shift) begin
			k_q <= k_q + AW'(1);
		end
	end

	// Entries leave the tail in ascending order; only the first n_old are live.
	// The cell in front of the tail holds the entry one step ahead.
	assign x_live = (CW'(k_q) < n_old_q);
	assign y_live = ((CW'(k_q) + CW'(1)) < n_old_q);

	ftws_merge #(
		.WINDOW (WINDOW),
		.AW     (AW)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.shift   (shift),
		.new_val (frame.frame_us),
		.x_live  (x_live),
		.x_val   (c_val[WINDOW-1]),
		.x_age   (c_age[WINDOW-1]),
		.y_live  (y_live),
		.y_val   (c_val[WINDOW-2]),
		.y_age   (c_age[WINDOW-2]),
		.e_live  (e_live),
		.e_val   (e_val),
		.e_age   (e_age)
	);

	// Ring of cells behind the merge cell
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			ftws_cell #(.AW(AW)) u_cell (
				.clk   (clk),
				.shift (shift),
				.d_val (e_val),
				.d_age (e_age),
				.q_val (c_val[i]),
				.q_age (c_age[i])
			);
		end else begin : g_body
			ftws_cell #(.AW(AW)) u_cell (
				.clk   (clk),
				.shift (shift),
				.d_val (c_val[i-1]),
				.d_age (c_age[i-1]),
				.q_val (c_val[i]),
				.q_age (c_age[i])
			);
		end
	end

	// Statistics over the sorted stream
	assign sctl.clear = accept;
	assign sctl.step  = shift;

	ftws_stats #(
		.CW  (CW),
		.NPW (NPW)
	) u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sctl),
		.np_in    (np),
		.n        (fill_q),
		.thr      (over_thr_q),
		.e_live   (e_live),
		.e_val    (e_val),
		.pct_val  (pct_val),
		.max_val  (max_val),
		.over_cnt (over_cnt)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (stats.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			samples_q <= ftws_pkg::CNT_W'(fill_q);
			pct_q     <= pct_val;
			max_q     <= max_val;
			over_q    <= ftws_pkg::CNT_W'(over_cnt);
		end
	end

	assign stats.valid      = out_valid_q;
	assign stats.samples    = samples_q;
	assign stats.pct_us     = pct_q;
	assign stats.max_us     = max_q;
	assign stats.over_count = over_q;

endmodule

@@ src/ftws_checker.sv @@
// Port-level checks for the frame-time statistics block
module ftws_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ftws_pkg::CNT_W-1:0] samples,
	input logic [ftws_pkg::DUR_W-1:0] pct_us,
	input logic [ftws_pkg::DUR_W-1:0] max_us,
	input logic [ftws_pkg::CNT_W-1:0] over_count
);

	// A stalled output beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pct_us) && $stable(max_us)
			&& $stable(samples) && $stable(over_count))
		else $error("output beat changed while stalled");

	// The block is busy for the lap after taking a beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	// The percentile value never exceeds the maximum
	a_pct_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pct_us <= max_us)
		else $error("percentile value above maximum");

	// A fresh result only appears at the end of a lap
	a_result_after_lap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a finished lap");

endmodule

bind frame_time_window_stats ftws_checker u_ftws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (frame.valid),
	.in_ready   (frame.ready),
	.out_valid  (stats.valid),
	.out_ready  (stats.ready),
	.samples    (stats.samples),
	.pct_us     (stats.pct_us),
	.max_us     (stats.max_us),
	.over_count (stats.over_count)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int unsigned DEPTH = ftws_pkg::WINDOW_DEF;
	localparam int unsigned QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [ftws_pkg::CNT_W-1:0] samples;
		logic [ftws_pkg::DUR_W-1:0] pct_us;
		logic [ftws_pkg::DUR_W-1:0] max_us;
		logic [ftws_pkg::CNT_W-1:0] over_count;
	} frame_stats_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ftws_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [ftws_pkg::CFG_DATA_W-1:0] cfg_wdata;

	ftws_in_if frame_if ();
	ftws_out_if stats_if ();

	frame_time_window_stats u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.frame    (frame_if),
		.stats    (stats_if)
	);

	// Shadow of the block: ring of durations and register copies
	logic [ftws_pkg::DUR_W-1:0] held_us [DEPTH];
	int unsigned                wr_pos;
	int unsigned                fill_n;
	logic [ftws_pkg::DUR_W-1:0] thr_cfg;
	logic [ftws_pkg::PCT_W-1:0] pct_cfg;

	frame_stats_t stats_due_q [$];

	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int unsigned frames_sent;
	int unsigned stats_checked = 0;
	int unsigned cfg_changes;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Statistics over the held durations, sorted ascending
	function automatic frame_stats_t window_stats();
		logic [ftws_pkg::DUR_W-1:0] v [DEPTH];
		logic [ftws_pkg::DUR_W-1:0] x;
		int unsigned i, j, rank, over;
		frame_stats_t r;
		for (i = 0; i < fill_n; i++)
			v[i] = held_us[i];
		for (i = 1; i < fill_n; i++) begin
			x = v[i];
			j = i;
			while (j > 0 && v[j-1] > x) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = x;
		end
		// ceiling rank, clamped to 1..fill_n
		rank = (fill_n * int'(pct_cfg) + int'(ftws_pkg::PCT_SCALE) - 1)
			/ int'(ftws_pkg::PCT_SCALE);
		if (rank == 0)
			rank = 1;
		if (rank > fill_n)
			rank = fill_n;
		over = 0;
		for (i = 0; i < fill_n; i++)
			if (v[i] > thr_cfg)
				over++;
		r.samples    = ftws_pkg::CNT_W'(fill_n);
		r.pct_us     = v[rank-1];
		r.max_us     = v[fill_n-1];
		r.over_count = ftws_pkg::CNT_W'(over);
		return r;
	endfunction

	// Store an accepted duration and queue the stats it produces
	task automatic record_frame(input logic [ftws_pkg::DUR_W-1:0] d);
		held_us[wr_pos] = d;
		wr_pos = (wr_pos + 1) % DEPTH;
		if (fill_n < DEPTH)
			fill_n++;
		stats_due_q.push_back(window_stats());
		frames_sent++;
	endtask

	// One input beat; valid stays high on return so back-to-back beats need no drop
	task automatic send_frame(input logic [ftws_pkg::DUR_W-1:0] d);
		while ($urandom_range(99) < src_idle_pct) begin
			frame_if.valid <= 1'b0;
			@(posedge clk);
		end
		frame_if.valid    <= 1'b1;
		frame_if.frame_us <= d;
		do @(posedge clk); while (!frame_if.ready);
		record_frame(d);
	endtask

	// Hold off input until every result is back, then let the lap finish
	task automatic wait_idle();
		frame_if.valid <= 1'b0;
		while (stats_due_q.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
	endtask

	// Write both registers while idle
	task automatic set_regs(input logic [ftws_pkg::DUR_W-1:0] thr,
			input logic [ftws_pkg::CFG_DATA_W-1:0] pct_word);
		cfg_we    <= 1'b1;
		cfg_idx   <= ftws_pkg::REG_OVER_THR;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_idx   <= ftws_pkg::REG_PERCENTILE;
		cfg_wdata <= pct_word;
		@(posedge clk);
		cfg_we    <= 1'b0;
		thr_cfg = thr;
		pct_cfg = pct_word[ftws_pkg::PCT_W-1:0];
		cfg_changes++;
	endtask

	// Mostly frame-rate durations, with spikes, ties, extremes and values at the threshold
	function automatic logic [ftws_pkg::DUR_W-1:0] rand_frame();
		logic [ftws_pkg::DUR_W-1:0] d;
		case ($urandom_range(9))
			0: d = $urandom;
			1: begin
				case ($urandom_range(3))
					0: d = '0;
					1: d = '1;
					2: d = ftws_pkg::DUR_W'(1) << $urandom_range(ftws_pkg::DUR_W-1);
					default: d = ~(ftws_pkg::DUR_W'(1) << $urandom_range(ftws_pkg::DUR_W-1));
				endcase
			end
			2: d = thr_cfg + ftws_pkg::DUR_W'($urandom_range(2)) - ftws_pkg::DUR_W'(1);
			3: d = $urandom_range(120000, 30000);
			4: d = ($urandom_range(1) != 0) ? ftws_pkg::DUR_W'(16667) : ftws_pkg::DUR_W'(33333);
			default: d = $urandom_range(17500, 16000);
		endcase
		return d;
	endfunction

	function automatic logic [ftws_pkg::CFG_DATA_W-1:0] rand_pct_word();
		logic [ftws_pkg::PCT_W-1:0] p;
		case ($urandom_range(7))
			0: p = '0;
			1: p = ftws_pkg::PCT_W'(1);
			2: p = ftws_pkg::PCT_SCALE;
			3: p = '1;
			4: p = ftws_pkg::PCT_W'($urandom);
			default: p = ftws_pkg::PCT_W'($urandom_range(100, 50));
		endcase
		// junk in the unused upper bits must be dropped
		return ($urandom & ~ftws_pkg::CFG_DATA_W'({ftws_pkg::PCT_W{1'b1}}))
			| ftws_pkg::CFG_DATA_W'(p);
	endfunction

	function automatic logic [ftws_pkg::DUR_W-1:0] rand_thr();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(60000, 16000);
		endcase
	endfunction

	// Result checker and receiver stalls
	always @(posedge clk) begin
		frame_stats_t got, want;
		if (arst_n) begin
			if (stats_if.valid && stats_if.ready) begin
				got.samples    = stats_if.samples;
				got.pct_us     = stats_if.pct_us;
				got.max_us     = stats_if.max_us;
				got.over_count = stats_if.over_count;
				if (stats_due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: stats beat with nothing pending: %p", $realtime, got);
				end else begin
					want = stats_due_q.pop_front();
					stats_checked++;
					if (got.samples !== want.samples || got.pct_us !== want.pct_us ||
							got.max_us !== want.max_us || got.over_count !== want.over_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: stats mismatch exp %p got %p", $realtime, want, got);
					end
				end
			end
			stats_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end else begin
			stats_if.ready <= 1'b0;
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_if.valid && frame_if.ready) || (stats_if.valid && stats_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no beat for %0d cycles", $realtime, QUIET_LIMIT);
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	// Edges of the duration range and ties under reset register values
	task automatic test_reset_values();
		send_frame('0);
		send_frame('1);
		send_frame(ftws_pkg::OVER_THR_RST);
		send_frame(ftws_pkg::OVER_THR_RST + ftws_pkg::DUR_W'(1));
		send_frame(ftws_pkg::DUR_W'(16667));
		send_frame(ftws_pkg::DUR_W'(16667));
		send_frame(ftws_pkg::DUR_W'(16667));
		send_frame(ftws_pkg::DUR_W'(1));
		send_frame(ftws_pkg::DUR_W'(32'h8000_0000));
		send_frame(ftws_pkg::OVER_THR_RST - ftws_pkg::DUR_W'(1));
		send_frame(ftws_pkg::DUR_W'(32'h7FFF_FFFF));
		send_frame(ftws_pkg::DUR_W'(33333));
	endtask

	// Percentile zero and above 100 saturate, plus percentile 1 and 100; threshold at both ends
	task automatic test_reg_extremes();
		wait_idle();
		set_regs('0, '0);
		send_frame(ftws_pkg::DUR_W'(5));
		send_frame('1);
		send_frame(ftws_pkg::DUR_W'(16667));
		wait_idle();
		set_regs('1, ftws_pkg::CFG_DATA_W'({ftws_pkg::PCT_W{1'b1}}));
		send_frame('0);
		send_frame('1);
		send_frame(ftws_pkg::DUR_W'(20000));
		wait_idle();
		set_regs(ftws_pkg::OVER_THR_RST, ftws_pkg::CFG_DATA_W'(1));
		send_frame(ftws_pkg::DUR_W'(70000));
		send_frame(ftws_pkg::DUR_W'(2));
		send_frame(ftws_pkg::DUR_W'(16667));
		wait_idle();
		set_regs(ftws_pkg::DUR_W'(16667), ftws_pkg::CFG_DATA_W'(ftws_pkg::PCT_SCALE));
		send_frame(ftws_pkg::DUR_W'(16668));
		send_frame(ftws_pkg::DUR_W'(16666));
		send_frame(ftws_pkg::DUR_W'(16667));
	endtask

	// Long traffic with register changes at random points
	task automatic test_random_traffic(input int unsigned src_idle, input int unsigned snk_idle,
			input int unsigned n_frames);
		int unsigned i, next_cfg;
		src_idle_pct = src_idle;
		snk_idle_pct = snk_idle;
		next_cfg = $urandom_range(120, 60);
		for (i = 0; i < n_frames; i++) begin
			if (i == next_cfg) begin
				wait_idle();
				set_regs(rand_thr(), rand_pct_word());
				next_cfg = i + $urandom_range(120, 60);
			end
			send_frame(rand_frame());
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = ftws_pkg::REG_OVER_THR;
		cfg_wdata         = '0;
		frame_if.valid    = 1'b0;
		frame_if.frame_us = '0;
		wr_pos            = 0;
		fill_n            = 0;
		thr_cfg           = ftws_pkg::OVER_THR_RST;
		pct_cfg           = ftws_pkg::PERCENTILE_RST;
		frames_sent       = 0;
		cfg_changes       = 0;
		src_idle_pct      = 14;
		snk_idle_pct      = 57;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_reg_extremes();
		test_random_traffic(14, 57, 350);
		test_random_traffic(57, 14, 350);
		test_random_traffic(0, 0, 350);
		wait_idle();

		$display("Ran %0d frames through the %0d-deep window, %0d stats beats checked,",
			frames_sent, DEPTH, stats_checked);
		$display("%0d register settings incl. percentile 0/1/100/127 and threshold 0/max.",
			cfg_changes);
		if (mismatches == 0 && stats_due_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
src/ftws_pkg.sv
src/ftws_in_if.sv
src/ftws_out_if.sv
src/ftws_cell.sv
src/ftws_merge.sv
src/ftws_stats.sv
src/frame_time_window_stats.sv
src/ftws_checker.sv
tb/tb.sv
